### hw/rtl/srec_pkg.sv
`timescale 1ns / 1ps

package srec_pkg;

   localparam int SREC_LINE_CHARS = 64;

   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_ACCEPT   = 3'd1;
   localparam logic [2:0] KIND_REJECT   = 3'd2;
   localparam logic [2:0] KIND_OVERFLOW = 3'd3;
   localparam logic [2:0] KIND_IMAGE    = 3'd4;

   localparam logic [31:0] NO_START  = 32'hFFFF_FFFF;
   localparam logic [7:0]  SUM_GOOD  = 8'hFF;
   localparam logic [7:0]  MIN_COUNT = 8'd5;

   localparam logic [7:0] CH_XON   = 8'h11;
   localparam logic [7:0] CH_XOFF  = 8'h13;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_S_UP  = 8'h53;
   localparam logic [7:0] CH_S_LO  = 8'h73;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_SEVEN = 8'h37;

   // {valid, nibble}
   function automatic logic [4:0] hex_nib(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

### hw/rtl/srecord_line_parser.sv
`timescale 1ns / 1ps

// S-record line parser (S3 and S7 records plus a <CRC> image line). One received
// character per req transaction; XON and XOFF are dropped, other characters go to a
// LINE_CHARS-deep line store. A CR or LF ends the line: the sequencer walks the
// store one character at a time, in an address state and a data state (one read
// port, registered read data), through a single hex/sum unit, then walks the data
// field again to emit one data-byte transaction per byte, and ends with one status
// transaction with rsp_tlast set. req_tready stays low from the end of a line until
// its status transaction is issued. rsp_tuser carries the result kind: 0 data byte,
// 1 line accepted, 2 line rejected, 3 line overflow, 4 image complete. A full line
// store sets the sticky error and reports overflow.
module srecord_line_parser #(
   parameter int LINE_CHARS = srec_pkg::SREC_LINE_CHARS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] ch
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [175:0] rsp_tdata,   // [31:0] address, [39:32] data_byte,
                                     // [71:40] start_addr, [103:72] image_base,
                                     // [135:104] image_len, [167:136] image_checksum,
                                     // [168] error_seen, [175:169] zero
   output logic [2:0]   rsp_tuser,   // [2:0] kind
   output logic         rsp_tlast
);

   import srec_pkg::*;

   localparam int AW = $clog2(LINE_CHARS);
   localparam int PW = $clog2(LINE_CHARS + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_ADDR, ST_DATA, ST_SEND, ST_FINAL} state_type;
   typedef enum logic [1:0] {MODE_S, MODE_CRC, MODE_EMIT} mode_type;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] fill_ff, fill_in;
   logic [3:0]  hi_ff, hi_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  nleft_ff, nleft_in;
   logic [7:0]  ndata_ff, ndata_in;
   logic [31:0] addr_ff, addr_in;
   logic [2:0]  final_ff, final_in;
   logic [7:0]  byte_ff, byte_in;
   logic        sticky_ff, sticky_in;
   logic [31:0] held_ff, held_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] crc_ff, crc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_start_ff, rsp_start_in;
   logic [31:0] rsp_base_ff, rsp_base_in;
   logic [31:0] rsp_len_ff, rsp_len_in;
   logic [31:0] rsp_crc_ff, rsp_crc_in;
   logic        rsp_err_ff, rsp_err_in;

   logic        req_fire;
   logic        slot_free;
   logic        ram_we;
   logic [7:0]  ram_rdata;
   logic [7:0]  cur_c;
   logic [4:0]  hx;
   logic [7:0]  byte_val;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign ram_we     = req_fire && req_tdata != CH_XON && req_tdata != CH_XOFF
                       && req_tdata != CH_CR && req_tdata != CH_LF;

   srec_ram #(
      .WIDTH (8),
      .DEPTH (LINE_CHARS)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[AW-1:0]),
      .wdata (req_tdata),
      .raddr (pos_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign cur_c    = (pos_ff < fill_ff) ? ram_rdata : 8'h00;
   assign hx       = hex_nib(cur_c);
   assign byte_val = {hi_ff, hx[3:0]};

   always_comb begin
      logic        reject;
      logic        crc_fail;
      logic [31:0] acc_next;
      logic [7:0]  sum_next;
      logic [7:0]  hdr;

      reject   = 1'b0;
      crc_fail = 1'b0;
      acc_next = {acc_ff[27:0], hx[3:0]};
      sum_next = sum_ff + byte_val;
      hdr      = CH_GT;

      state_in = state_ff;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      fill_in  = fill_ff;
      hi_in    = hi_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      type_in  = type_ff;
      nleft_in = nleft_ff;
      ndata_in = ndata_ff;
      addr_in  = addr_ff;
      final_in = final_ff;
      byte_in  = byte_ff;
      sticky_in = sticky_ff;
      held_in  = held_ff;
      base_in  = base_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_start_in = rsp_start_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_crc_in   = rsp_crc_ff;
      rsp_err_in   = rsp_err_ff;

      case (pos_ff)
         PW'(1):  hdr = CH_C;
         PW'(2):  hdr = CH_R;
         PW'(3):  hdr = CH_C;
         default: hdr = CH_GT;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tdata != CH_XON && req_tdata != CH_XOFF) begin
               if (req_tdata == CH_CR || req_tdata == CH_LF) begin
                  if (fill_ff != '0) begin
                     pos_in   = '0;
                     mode_in  = MODE_S;
                     acc_in   = '0;
                     addr_in  = '0;
                     state_in = ST_ADDR;
                  end
               end else if (fill_ff == PW'(LINE_CHARS - 1)) begin
                  fill_in   = '0;
                  sticky_in = 1'b1;
                  final_in  = KIND_OVERFLOW;
                  state_in  = ST_FINAL;
               end else begin
                  fill_in = fill_ff + PW'(1);
               end
            end
         end
         ST_ADDR: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            state_in = ST_ADDR;
            pos_in   = pos_ff + PW'(1);
            if (pos_ff == '0) begin
               if (cur_c == CH_LT) begin
                  mode_in = MODE_CRC;
               end else if (cur_c == CH_S_UP || cur_c == CH_S_LO) begin
                  mode_in = MODE_S;
               end else begin
                  reject = 1'b1;
               end
            end else begin
               case (mode_ff)
                  MODE_CRC: begin
                     if (pos_ff <= PW'(4)) begin
                        if (cur_c != hdr) begin
                           reject = 1'b1;
                        end
                     end else if (pos_ff inside {PW'(13), PW'(22), PW'(31)}) begin
                        acc_in = acc_ff;
                     end else if (!hx[4]) begin
                        crc_fail = 1'b1;
                     end else begin
                        acc_in = acc_next;
                        if (pos_ff == PW'(12)) begin
                           base_in = acc_next;
                        end
                        if (pos_ff == PW'(21)) begin
                           len_in = acc_next;
                        end
                        if (pos_ff == PW'(30)) begin
                           crc_in = acc_next;
                        end
                        if (pos_ff == PW'(39)) begin
                           held_in  = acc_next;
                           final_in = KIND_ACCEPT;
                           state_in = ST_FINAL;
                        end
                     end
                  end
                  MODE_S: begin
                     if (pos_ff == PW'(1)) begin
                        type_in = cur_c;
                     end else if (!hx[4]) begin
                        reject = 1'b1;
                     end else if (!pos_ff[0]) begin
                        hi_in = hx[3:0];
                     end else if (pos_ff == PW'(3)) begin
                        sum_in = byte_val;
                        if (byte_val < MIN_COUNT
                            || (type_ff != CH_THREE && type_ff != CH_SEVEN)) begin
                           reject = 1'b1;
                        end
                        nleft_in = (type_ff == CH_THREE) ? byte_val - MIN_COUNT : 8'd0;
                        ndata_in = nleft_in;
                     end else if (pos_ff < PW'(12)) begin
                        addr_in = {addr_ff[23:0], byte_val};
                        sum_in  = sum_next;
                     end else if (nleft_ff != 8'd0) begin
                        sum_in   = sum_next;
                        nleft_in = nleft_ff - 8'd1;
                     end else if (sum_next == SUM_GOOD) begin
                        if (type_ff == CH_SEVEN) begin
                           held_in = addr_ff;
                        end
                        if (ndata_ff != 8'd0) begin
                           mode_in = MODE_EMIT;
                           pos_in  = PW'(12);
                        end else begin
                           final_in = KIND_ACCEPT;
                           state_in = ST_FINAL;
                        end
                     end else begin
                        reject = 1'b1;
                     end
                  end
                  MODE_EMIT: begin
                     if (!pos_ff[0]) begin
                        hi_in = hx[3:0];
                     end else begin
                        byte_in  = byte_val;
                        pos_in   = pos_ff;
                        state_in = ST_SEND;
                     end
                  end
                  default: begin
                     reject = 1'b1;
                  end
               endcase
            end
            if (crc_fail) begin
               base_in = '0;
               len_in  = '0;
               crc_in  = '0;
               held_in = NO_START;
               reject  = 1'b1;
            end
            if (reject) begin
               sticky_in = 1'b1;
               final_in  = KIND_REJECT;
               state_in  = ST_FINAL;
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DATA;
               rsp_addr_in  = addr_ff;
               rsp_data_in  = byte_ff;
               rsp_last_in  = 1'b0;
               rsp_start_in = held_ff;
               rsp_base_in  = base_ff;
               rsp_len_in   = len_ff;
               rsp_crc_in   = crc_ff;
               rsp_err_in   = sticky_ff;
               addr_in      = addr_ff + 32'd1;
               ndata_in     = ndata_ff - 8'd1;
               if (ndata_ff == 8'd1) begin
                  final_in = KIND_ACCEPT;
                  state_in = ST_FINAL;
               end else begin
                  pos_in   = pos_ff + PW'(1);
                  state_in = ST_ADDR;
               end
            end
         end
         ST_FINAL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_start_in = held_ff;
               rsp_base_in  = base_ff;
               rsp_len_in   = len_ff;
               rsp_crc_in   = crc_ff;
               if (final_ff == KIND_ACCEPT && held_ff != NO_START) begin
                  rsp_kind_in = KIND_IMAGE;
                  rsp_err_in  = 1'b0;
                  held_in     = NO_START;
                  sticky_in   = 1'b0;
               end else begin
                  rsp_kind_in = final_ff;
                  rsp_err_in  = sticky_ff;
               end
               fill_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         sticky_ff    <= 1'b0;
         held_ff      <= NO_START;
         base_ff      <= '0;
         len_ff       <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sticky_ff    <= sticky_in;
         held_ff      <= held_in;
         base_ff      <= base_in;
         len_ff       <= len_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      pos_ff       <= pos_in;
      hi_ff        <= hi_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
      type_ff      <= type_in;
      nleft_ff     <= nleft_in;
      ndata_ff     <= ndata_in;
      addr_ff      <= addr_in;
      final_ff     <= final_in;
      byte_ff      <= byte_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_start_ff <= rsp_start_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_crc_ff   <= rsp_crc_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_err_ff, rsp_crc_ff, rsp_len_ff, rsp_base_ff,
                        rsp_start_ff, rsp_data_ff, rsp_addr_ff};

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < PW'(LINE_CHARS))
      else $error("line store fill out of range");

   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_DATA |-> !rsp_last_ff)
      else $error("data byte marked last");

   a_image_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_IMAGE |-> !rsp_err_ff && rsp_start_ff != NO_START)
      else $error("image complete with error or no start");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("accepting while parsing");
`endif

endmodule

### hw/rtl/srec_ram.sv
`timescale 1ns / 1ps

module srec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
